// File: design/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/hawc_pkg.sv
// Types and constants of the hex axial and world position converter.
package hawc_pkg;

    localparam logic signed [25:0] SQRT3_Q24 = 26'sd29058991;
    localparam int QB = 34;
    localparam int RW = 43;
    localparam int NW = 60;
    localparam logic [15:0] CIRCUMRADIUS_RESET = 16'd256;
    localparam logic CFG_CIRCUMRADIUS = 1'b0;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] hex_q;
        logic signed [15:0] hex_r;
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] out_world_x;
        logic signed [31:0] out_world_y;
        logic signed [15:0] out_q;
        logic signed [15:0] out_r;
        logic               saturated;
    } out_word_t;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [QB-1:0] dq;
        logic          neg;
    } lane_t;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic               sat0;
        logic [RW-1:0]      dd;
        lane_t [2:0]        lanes;
    } cell_word_t;

endpackage

// File: design/hawc_front.sv
// Front stages: products, axial numerators and sign folding for the divider.
module hawc_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [15:0]          circumradius,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hawc_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hawc_pkg::cell_word_t out_data
);

    localparam int NW = hawc_pkg::NW;
    localparam int RW = hawc_pkg::RW;
    localparam int QB = hawc_pkg::QB;

    logic                 v1_reg, v2_reg, v3_reg;
    logic                 rdy1, rdy2, rdy3;

    logic                 mode1_reg;
    logic signed [34:0]   t0_reg, t0_next;
    logic signed [34:0]   py1_reg, py1_next;
    logic signed [57:0]   xs_reg, xs_next;
    logic signed [31:0]   y_reg;
    logic [17:0]          dsz_reg, dsz_next;

    logic                 mode2_reg;
    logic signed [60:0]   px_reg, px_next;
    logic signed [34:0]   py2_reg;
    logic signed [NW-1:0] nq_reg, nq_next, nr_reg, nr_next, ns_reg, ns_next;
    logic [41:0]          d_reg;

    hawc_pkg::cell_word_t c_reg, c_next;

    logic signed [17:0]   two_q_r, three_r;
    logic signed [16:0]   size_s;
    logic [15:0]          size1;

    assign rdy3 = !v3_reg || out_ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign out_valid = v3_reg;
    assign out_data = c_reg;

    always_comb begin
        two_q_r  = 18'(in_data.hex_q) + 18'(in_data.hex_q) + 18'(in_data.hex_r);
        three_r  = 18'(in_data.hex_r) + 18'(in_data.hex_r) + 18'(in_data.hex_r);
        size_s   = signed'({1'b0, circumradius});
        t0_next  = 35'(two_q_r) * 35'(size_s);
        py1_next = 35'(three_r) * 35'(size_s);
        xs_next  = 58'(in_data.world_x) * 58'(hawc_pkg::SQRT3_Q24);
        size1    = (circumradius == 16'd0) ? 16'd1 : circumradius;
        dsz_next = {2'b00, size1} + {1'b0, size1, 1'b0};
    end

    always_comb begin
        px_next = 61'(t0_reg) * 61'(hawc_pkg::SQRT3_Q24);
        nq_next = NW'(xs_reg) - (NW'(y_reg) <<< 24);
        nr_next = NW'(y_reg) <<< 25;
        ns_next = NW'(0) - NW'(xs_reg) + (NW'(y_reg) <<< 24) - (NW'(y_reg) <<< 25);
    end

    always_comb begin
        logic signed [NW-1:0] n_num [3];
        logic signed [NW-1:0] n_all;
        logic [NW-1:0]        a_mag;
        logic signed [60:0]   pxr;
        logic signed [34:0]   pyr;
        n_num[0] = nq_reg;
        n_num[1] = nr_reg;
        n_num[2] = ns_reg;
        c_next = '0;
        c_next.mode = mode2_reg;
        c_next.dd = {d_reg, 1'b0};
        for (int i = 0; i < 3; i++) begin
            n_all = (n_num[i] <<< 1) + signed'(NW'(d_reg));
            a_mag = n_all[NW-1] ? ~n_all : n_all;
            c_next.lanes[i].neg = n_all[NW-1];
            c_next.lanes[i].rem = RW'(a_mag[NW-1:QB]);
            c_next.lanes[i].dq  = a_mag[QB-1:0];
        end
        pxr = (px_reg + (61'sd1 <<< 24)) >>> 25;
        pyr = (py2_reg + 35'sd1) >>> 1;
        c_next.sat0 = 1'b0;
        if (pxr > 61'sd2147483647) begin
            c_next.wx = 32'sh7fffffff;
            c_next.sat0 = 1'b1;
        end else if (pxr < -61'sd2147483648) begin
            c_next.wx = 32'sh80000000;
            c_next.sat0 = 1'b1;
        end else begin
            c_next.wx = pxr[31:0];
        end
        if (pyr > 35'sd2147483647) begin
            c_next.wy = 32'sh7fffffff;
            c_next.sat0 = 1'b1;
        end else if (pyr < -35'sd2147483648) begin
            c_next.wy = 32'sh80000000;
            c_next.sat0 = 1'b1;
        end else begin
            c_next.wy = pyr[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            mode1_reg <= in_data.mode;
            t0_reg    <= t0_next;
            py1_reg   <= py1_next;
            xs_reg    <= xs_next;
            y_reg     <= in_data.world_y;
            dsz_reg   <= dsz_next;
        end
        if (rdy2) begin
            mode2_reg <= mode1_reg;
            px_reg    <= px_next;
            py2_reg   <= py1_reg;
            nq_reg    <= nq_next;
            nr_reg    <= nr_next;
            ns_reg    <= ns_next;
            d_reg     <= {dsz_reg, 24'b0};
        end
        if (rdy3) c_reg <= c_next;
    end

endmodule

// File: design/hawc_div_cell.sv
// Divider cell: one restoring quotient bit for each of the three lanes.
module hawc_div_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hawc_pkg::cell_word_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hawc_pkg::cell_word_t out_data
);

    localparam int RW = hawc_pkg::RW;
    localparam int QB = hawc_pkg::QB;

    logic                 valid_reg;
    hawc_pkg::cell_word_t data_reg, data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        logic [RW:0] trial;
        logic        ge;
        data_next = in_data;
        for (int i = 0; i < 3; i++) begin
            trial = {in_data.lanes[i].rem, in_data.lanes[i].dq[QB-1]};
            ge = trial >= {1'b0, in_data.dd};
            data_next.lanes[i].rem = ge ? RW'(trial - {1'b0, in_data.dd}) : RW'(trial);
            data_next.lanes[i].dq  = {in_data.lanes[i].dq[QB-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) data_reg <= data_next;
    end

endmodule

// File: design/hawc_back.sv
// Back stages: unfold quotients, rounding errors, correction and clamping.
module hawc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hawc_pkg::cell_word_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hawc_pkg::out_word_t  out_data
);

    localparam int RW = hawc_pkg::RW;

    logic               ve_reg, vf_reg;
    logic               rdye, rdyf;

    logic               mode_reg;
    logic signed [31:0] wx_reg, wy_reg;
    logic               sat0_reg;
    logic signed [35:0] q_reg [3];
    logic signed [35:0] q_next [3];
    logic [RW-1:0]      e_reg [3];
    logic [RW-1:0]      e_next [3];

    hawc_pkg::out_word_t o_reg, o_next;

    assign rdyf = !vf_reg || out_ready;
    assign rdye = !ve_reg || rdyf;
    assign in_ready  = rdye;
    assign out_valid = vf_reg;
    assign out_data  = o_reg;

    always_comb begin
        logic [RW-1:0]      m;
        logic signed [RW:0] diff;
        for (int i = 0; i < 3; i++) begin
            if (in_data.lanes[i].neg) begin
                q_next[i] = -signed'(36'(in_data.lanes[i].dq)) - 36'sd1;
                m = in_data.dd - RW'(1) - in_data.lanes[i].rem;
            end else begin
                q_next[i] = signed'(36'(in_data.lanes[i].dq));
                m = in_data.lanes[i].rem;
            end
            diff = signed'({2'b00, in_data.dd[RW-1:1]}) - signed'({1'b0, m});
            e_next[i] = diff[RW] ? RW'(-diff) : RW'(diff);
        end
    end

    always_comb begin
        logic signed [36:0] fq, fr;
        o_next = '0;
        fq = 37'(q_reg[0]);
        fr = 37'(q_reg[1]);
        if (e_reg[0] > e_reg[1] && e_reg[0] > e_reg[2]) begin
            fq = -37'(q_reg[1]) - 37'(q_reg[2]);
        end else if (e_reg[1] > e_reg[2]) begin
            fr = -37'(q_reg[0]) - 37'(q_reg[2]);
        end
        if (mode_reg) begin
            if (fq > 37'sd32767) begin
                o_next.out_q = 16'sh7fff;
                o_next.saturated = 1'b1;
            end else if (fq < -37'sd32768) begin
                o_next.out_q = 16'sh8000;
                o_next.saturated = 1'b1;
            end else begin
                o_next.out_q = fq[15:0];
            end
            if (fr > 37'sd32767) begin
                o_next.out_r = 16'sh7fff;
                o_next.saturated = 1'b1;
            end else if (fr < -37'sd32768) begin
                o_next.out_r = 16'sh8000;
                o_next.saturated = 1'b1;
            end else begin
                o_next.out_r = fr[15:0];
            end
        end else begin
            o_next.out_world_x = wx_reg;
            o_next.out_world_y = wy_reg;
            o_next.saturated   = sat0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
        end else begin
            if (rdye) ve_reg <= in_valid;
            if (rdyf) vf_reg <= ve_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdye) begin
            mode_reg <= in_data.mode;
            wx_reg   <= in_data.wx;
            wy_reg   <= in_data.wy;
            sat0_reg <= in_data.sat0;
            q_reg    <= q_next;
            e_reg    <= e_next;
        end
        if (rdyf) o_reg <= o_next;
    end

endmodule

// File: design/hex_axial_world_converter.sv
// Top level of the pointy-top hex axial and world position converter.
// One word enters per cycle unless a stall holds the pipeline: three front
// stages form the products and axial numerators, a chain of 34 divider cells
// resolves one quotient bit per cell for q, r and s, and two back stages pick
// the rounded cell and clamp. Each stage holds its word until the next one
// frees, so a stalled output lets the pipeline keep filling its empty stages.
`include "assert_macros.svh"

module hex_axial_world_converter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hawc_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hawc_pkg::out_word_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int QB = hawc_pkg::QB;

    logic [15:0]          circumradius_reg;

    hawc_pkg::cell_word_t chain_data  [QB+1];
    logic                 chain_valid [QB+1];
    logic                 chain_ready [QB+1];

    logic                 cell_nonzero, world_zero, sat_cell, cell_clamped, last_stalled;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == hawc_pkg::CFG_CIRCUMRADIUS)
                    ? {16'b0, circumradius_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            circumradius_reg <= hawc_pkg::CIRCUMRADIUS_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == hawc_pkg::CFG_CIRCUMRADIUS) begin
            circumradius_reg <= pwdata[15:0];
        end
    end

    hawc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .circumradius (circumradius_reg),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_data      (s_data),
        .out_valid    (chain_valid[0]),
        .out_ready    (chain_ready[0]),
        .out_data     (chain_data[0])
    );

    for (genvar i = 0; i < QB; i++) begin : g_cell
        hawc_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    hawc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (chain_valid[QB]),
        .in_ready  (chain_ready[QB]),
        .in_data   (chain_data[QB]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    assign cell_nonzero = m_data.out_q != 16'sd0 || m_data.out_r != 16'sd0;
    assign world_zero   = m_data.out_world_x == 32'sd0 && m_data.out_world_y == 32'sd0;
    assign sat_cell     = m_data.saturated && world_zero;
    assign cell_clamped = m_data.out_q == 16'sh7fff || m_data.out_q == 16'sh8000
                          || m_data.out_r == 16'sh7fff || m_data.out_r == 16'sh8000;
    assign last_stalled = chain_valid[QB] && !chain_ready[QB];

    `ASSERT_IMPLY(a_cell_clears_world, aclk, aresetn, m_valid && cell_nonzero, world_zero)
    `ASSERT_IMPLY(a_cell_sat_clamped, aclk, aresetn, m_valid && sat_cell, cell_clamped)
    `ASSERT_NEXT(a_last_cell_holds, aclk, aresetn, last_stalled, chain_valid[QB] && $stable(chain_data[QB]))

endmodule
